// ===== rtl/bd2_pkg.sv =====
// Shared types and constants for the 2x2 box downsampler.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package bd2_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;

    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int PIX_W       = 8;
    localparam int SUM_W       = PIX_W + 1;
    localparam int BLOCK_W     = PIX_W + 2;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int BUF_DEPTH   = MAX_WIDTH / 2;
    localparam int ADDR_W      = $clog2(BUF_DEPTH);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    typedef enum logic {
        OP_STORE,
        OP_EMIT
    } op_t;

    // One unit of work for the back end: store a pair sum or emit a block.
    typedef struct packed {
        op_t              op;
        logic [ADDR_W-1:0] addr;
        logic [SUM_W-1:0]  pair_sum;
        logic              frame_end;
    } job_t;

endpackage

// ===== rtl/bd2_front.sv =====
// Front end: configuration registers, raster position tracking and job classification.
// Depends on bd2_pkg.
`timescale 1ns / 1ps

module bd2_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [bd2_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bd2_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bd2_pkg::PIX_W-1:0]     s_pixel,
    input  logic                          q_full,
    output logic                          q_push,
    output bd2_pkg::job_t                 q_job
);

    logic [bd2_pkg::CFG_W-1:0] frame_width_reg, frame_width_next;
    logic [bd2_pkg::CFG_W-1:0] frame_height_reg, frame_height_next;
    logic [bd2_pkg::PIX_W-1:0] held_pixel_reg, held_pixel_next;
    logic [bd2_pkg::COL_W-1:0] col_reg, col_next;
    logic [bd2_pkg::ROW_W-1:0] row_reg, row_next;

    logic [bd2_pkg::CFG_W-1:0] eff_w, eff_h, even_w, even_h;
    logic [bd2_pkg::CFG_W-1:0] col_ext, row_ext, col_inc, row_inc;
    logic                      accept, in_frame, col_last, row_last;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (frame_width_reg == '0) begin
            eff_w = bd2_pkg::CFG_W'(1);
        end else if (frame_width_reg > bd2_pkg::CFG_W'(bd2_pkg::MAX_WIDTH)) begin
            eff_w = bd2_pkg::CFG_W'(bd2_pkg::MAX_WIDTH);
        end else begin
            eff_w = frame_width_reg;
        end
        if (frame_height_reg == '0) begin
            eff_h = bd2_pkg::CFG_W'(1);
        end else if (frame_height_reg > bd2_pkg::CFG_W'(bd2_pkg::MAX_HEIGHT)) begin
            eff_h = bd2_pkg::CFG_W'(bd2_pkg::MAX_HEIGHT);
        end else begin
            eff_h = frame_height_reg;
        end
    end

    assign even_w   = {eff_w[bd2_pkg::CFG_W-1:1], 1'b0};
    assign even_h   = {eff_h[bd2_pkg::CFG_W-1:1], 1'b0};
    assign col_ext  = bd2_pkg::CFG_W'(col_reg);
    assign row_ext  = bd2_pkg::CFG_W'(row_reg);
    assign col_inc  = col_ext + bd2_pkg::CFG_W'(1);
    assign row_inc  = row_ext + bd2_pkg::CFG_W'(1);
    assign in_frame = (col_ext < even_w) && (row_ext < even_h);
    // Positions beyond a shrunk size count as the last of their row or frame
    assign col_last = col_inc >= eff_w;
    assign row_last = row_inc >= eff_h;

    // Odd columns inside the even area produce a job; even columns only hold the pixel
    assign q_push         = accept && in_frame && col_reg[0];
    assign q_job.op       = row_reg[0] ? bd2_pkg::OP_EMIT : bd2_pkg::OP_STORE;
    assign q_job.addr     = col_reg[bd2_pkg::COL_W-1:1];
    assign q_job.pair_sum = bd2_pkg::SUM_W'(held_pixel_reg) + bd2_pkg::SUM_W'(s_pixel);
    assign q_job.frame_end = (col_inc == even_w) && (row_inc == even_h);

    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_valid) begin
            case (cfg_index)
                bd2_pkg::REG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                bd2_pkg::REG_FRAME_HEIGHT: frame_height_next = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        held_pixel_next = held_pixel_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        if (accept) begin
            if (in_frame && !col_reg[0]) begin
                held_pixel_next = s_pixel;
            end
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_inc[bd2_pkg::ROW_W-1:0];
            end else begin
                col_next = col_inc[bd2_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= bd2_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= bd2_pkg::FRAME_HEIGHT_RST;
            held_pixel_reg   <= '0;
            col_reg          <= '0;
            row_reg          <= '0;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            held_pixel_reg   <= held_pixel_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
        end
    end

endmodule

// ===== rtl/bd2_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on bd2_pkg.
`timescale 1ns / 1ps

module bd2_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bd2_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output bd2_pkg::job_t head_job
);

    bd2_pkg::job_t                slots_reg [bd2_pkg::QUEUE_DEPTH];
    logic [bd2_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [bd2_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [bd2_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                         do_pop;

    assign full       = count_reg == bd2_pkg::QCNT_W'(bd2_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = slots_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue push while full");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= bd2_pkg::QCNT_W'(bd2_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    a_count_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow push");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != bd2_pkg::QCNT_W'(bd2_pkg::QUEUE_DEPTH))
            |-> (wr_ptr_reg - rd_ptr_reg) == count_reg[bd2_pkg::QPTR_W-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/bd2_back.sv =====
// Back end: line buffer of pair sums, block sum and registered output stage.
// Depends on bd2_pkg.
`timescale 1ns / 1ps

module bd2_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    input  bd2_pkg::job_t             q_job,
    output logic                      q_pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [bd2_pkg::PIX_W-1:0] m_out_pixel,
    output logic                      m_frame_end
);

    logic [bd2_pkg::SUM_W-1:0] pair_sums_mem [bd2_pkg::BUF_DEPTH];
    logic [bd2_pkg::SUM_W-1:0] rd_data_reg;

    logic                      s1_valid_reg, s1_valid_next;
    logic [bd2_pkg::SUM_W-1:0] s1_sum_reg;
    logic                      s1_end_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [bd2_pkg::PIX_W-1:0] out_pixel_reg;
    logic                      out_end_reg;

    logic                        adv_out, s1_free, pop_store, pop_emit;
    logic [bd2_pkg::BLOCK_W-1:0] block_sum;

    assign adv_out   = !out_valid_reg || m_ready;
    assign s1_free   = !s1_valid_reg || adv_out;
    assign q_pop     = q_valid && s1_free;
    assign pop_store = q_pop && (q_job.op == bd2_pkg::OP_STORE);
    assign pop_emit  = q_pop && (q_job.op == bd2_pkg::OP_EMIT);
    assign block_sum = bd2_pkg::BLOCK_W'(rd_data_reg) + bd2_pkg::BLOCK_W'(s1_sum_reg);

    // Store jobs finish in the buffer write; only emit jobs enter the sum stage
    always_ff @(posedge aclk) begin
        if (pop_store) begin
            pair_sums_mem[q_job.addr] <= q_job.pair_sum;
        end
        if (pop_emit) begin
            rd_data_reg <= pair_sums_mem[q_job.addr];
            s1_sum_reg  <= q_job.pair_sum;
            s1_end_reg  <= q_job.frame_end;
        end
        if (adv_out && s1_valid_reg) begin
            out_pixel_reg <= block_sum[bd2_pkg::BLOCK_W-1:2];
            out_end_reg   <= s1_end_reg;
        end
    end

    always_comb begin
        s1_valid_next  = s1_free ? pop_emit : s1_valid_reg;
        out_valid_next = adv_out ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_out_pixel = out_pixel_reg;
    assign m_frame_end = out_end_reg;

`ifndef SYNTHESIS
    a_store_no_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_store && !pop_emit) |=> !s1_valid_reg)
        else $error("store job entered the sum stage");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !adv_out) |=> s1_valid_reg && $stable(s1_sum_reg))
        else $error("sum stage lost a block while stalled");

    a_emit_reaches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && adv_out) |=> out_valid_reg)
        else $error("block did not reach the output register");
`endif

endmodule

// ===== rtl/box_downsample_2x2_top.sv =====
// Top level of the 2x2 box downsampler: front end, job queue and back end.
// Depends on bd2_pkg, bd2_front, bd2_queue and bd2_back.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    s_pixel
//   m_       out        m_valid/m_ready    m_out_pixel, m_frame_end
//   cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One pixel per clock while s_ready is high; results pass queue, s1 and out stages.
// The line buffer is one 1024 x 9 memory, one write or one read per cycle.
// Reset is synchronous on aresetn; the line buffer is not cleared.
// s_ready drops only while the four-entry job queue is full; cfg_ready is always high.
`timescale 1ns / 1ps

module box_downsample_2x2_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bd2_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bd2_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bd2_pkg::PIX_W-1:0]     s_pixel,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bd2_pkg::PIX_W-1:0]     m_out_pixel,
    output logic                          m_frame_end
);

    logic          q_full, q_push, q_pop, q_valid;
    bd2_pkg::job_t push_job, head_job;

    assign cfg_ready = 1'b1;

    bd2_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    bd2_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (head_job)
    );

    bd2_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_job       (head_job),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_pixel (m_out_pixel),
        .m_frame_end (m_frame_end)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for box_downsample_2x2_top: streams pixel frames and
// register writes, predicts every 2x2 block average and checks each result.
// Depends on bd2_pkg and the downsampler RTL; needs nothing else.
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PIXELS  = 700;

    // Indexes with no register behind them
    localparam logic [bd2_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [bd2_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SOURCE,
        IDLE_SINK,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [bd2_pkg::PIX_W-1:0] avg;
        logic                      last;
    } block_result_t;

    typedef struct packed {
        bit                            is_reg_write;
        logic [bd2_pkg::CFG_IDX_W-1:0] reg_index;
        logic [bd2_pkg::CFG_W-1:0]     reg_value;
        logic [bd2_pkg::PIX_W-1:0]     pixel;
        bit                            has_result;
        block_result_t                 result;
    } plan_row_t;

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_valid   = 1'b0;
    logic                          cfg_ready;
    logic [bd2_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
    logic [bd2_pkg::CFG_W-1:0]     cfg_data    = '0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic [bd2_pkg::PIX_W-1:0]     s_pixel     = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic [bd2_pkg::PIX_W-1:0]     m_out_pixel;
    logic                          m_frame_end;

    // Predictor state
    logic [bd2_pkg::CFG_W-1:0]  frame_width_reg  = bd2_pkg::FRAME_WIDTH_RST;
    logic [bd2_pkg::CFG_W-1:0]  frame_height_reg = bd2_pkg::FRAME_HEIGHT_RST;
    logic [bd2_pkg::SUM_W-1:0]  pair_sum_mem [bd2_pkg::BUF_DEPTH];
    logic [bd2_pkg::PIX_W-1:0]  left_pixel = '0;
    int unsigned                col_pos = 0;
    int unsigned                row_pos = 0;

    block_result_t     pending_blocks [$];
    int unsigned       src_idle_pct   = 0;
    int unsigned       sink_stall_pct = 0;
    int unsigned       pixels_sent    = 0;
    int unsigned       error_count    = 0;
    int unsigned       quiet_cycles   = 0;

    always #CLK_HALF aclk = ~aclk;

    box_downsample_2x2_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_pixel (m_out_pixel),
        .m_frame_end (m_frame_end)
    );

    function automatic int unsigned clamp_dim(input logic [bd2_pkg::CFG_W-1:0] v,
                                              input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the raster position by one pixel; returns 1 when a block completes
    function automatic bit downsample_step(input logic [bd2_pkg::PIX_W-1:0] px,
                                           output block_result_t res);
        int unsigned                 w;
        int unsigned                 h;
        int unsigned                 w_even;
        int unsigned                 h_even;
        int unsigned                 idx;
        logic [bd2_pkg::BLOCK_W-1:0] sum;
        bit                          produced;
        w        = clamp_dim(frame_width_reg, bd2_pkg::MAX_WIDTH);
        h        = clamp_dim(frame_height_reg, bd2_pkg::MAX_HEIGHT);
        w_even   = w - (w % 2);
        h_even   = h - (h % 2);
        produced = 1'b0;
        res      = '0;
        if (col_pos < w_even && row_pos < h_even) begin
            idx = col_pos >> 1;
            if (col_pos % 2 == 0) begin
                left_pixel = px;
            end else if (row_pos % 2 == 0) begin
                pair_sum_mem[idx] = left_pixel + px;
            end else begin
                sum      = pair_sum_mem[idx] + left_pixel + px;
                res.avg  = sum[bd2_pkg::BLOCK_W-1:2];
                res.last = (col_pos + 1 == w_even) && (row_pos + 1 == h_even);
                produced = 1'b1;
            end
        end
        // Past the end of a shrunk row or frame, wrap rather than carry on
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        return produced;
    endfunction

    function automatic logic [bd2_pkg::CFG_W-1:0] random_dim(input int unsigned usual_hi,
                                                             input int unsigned rare_hi);
        int unsigned r = $urandom_range(99);
        if (r < 10) return bd2_pkg::CFG_W'($urandom_range(1));
        if (r < 85) return bd2_pkg::CFG_W'($urandom_range(usual_hi, 2));
        return bd2_pkg::CFG_W'($urandom_range(rare_hi, usual_hi + 1));
    endfunction

    function automatic logic [bd2_pkg::PIX_W-1:0] any_pixel();
        int unsigned r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return bd2_pkg::PIX_W'($urandom_range(255));
    endfunction

    function automatic plan_row_t reg_row(input logic [bd2_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [bd2_pkg::CFG_W-1:0] val);
        plan_row_t r = '0;
        r.is_reg_write = 1'b1;
        r.reg_index    = idx;
        r.reg_value    = val;
        return r;
    endfunction

    function automatic plan_row_t pixel_row(input logic [bd2_pkg::PIX_W-1:0] px,
                                            input bit typed,
                                            input logic [bd2_pkg::PIX_W-1:0] avg,
                                            input bit last);
        plan_row_t r = '0;
        r.pixel       = px;
        r.has_result  = typed;
        r.result.avg  = avg;
        r.result.last = last;
        return r;
    endfunction

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:   begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SOURCE: begin src_idle_pct = 57; sink_stall_pct = 0;  end
            IDLE_SINK:   begin src_idle_pct = 0;  sink_stall_pct = 57; end
            default:     begin src_idle_pct = 13; sink_stall_pct = 13; end
        endcase
    endtask

    // Send one pixel transaction; a typed result overrides the predictor's
    task automatic feed_pixel(input logic [bd2_pkg::PIX_W-1:0] px, input bit typed,
                              input block_result_t typed_res);
        block_result_t res;
        bit            produced;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        produced = downsample_step(px, res);
        if (typed) pending_blocks.push_back(typed_res);
        else if (produced) pending_blocks.push_back(res);
        pixels_sent++;
    endtask

    task automatic finish_frame();
        while (col_pos != 0 || row_pos != 0) feed_pixel(any_pixel(), 1'b0, '0);
    endtask

    task automatic send_frame();
        feed_pixel(any_pixel(), 1'b0, '0);
        finish_frame();
    endtask

    // Hold off until every block is out and the pipeline has emptied
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_blocks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [bd2_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bd2_pkg::CFG_W-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        // Drop writes to unused indexes
        case (idx)
            bd2_pkg::REG_FRAME_WIDTH:  frame_width_reg  = val;
            bd2_pkg::REG_FRAME_HEIGHT: frame_height_reg = val;
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        block_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_blocks.size() == 0) begin
                $error("unexpected result: out_pixel %0d frame_end %0b",
                       m_out_pixel, m_frame_end);
                error_count++;
            end else begin
                want = pending_blocks.pop_front();
                if (m_out_pixel !== want.avg) begin
                    $error("out_pixel: expected %0d, actual %0d", want.avg, m_out_pixel);
                    error_count++;
                end
                if (m_frame_end !== want.last) begin
                    $error("frame_end: expected %0b, actual %0b", want.last, m_frame_end);
                    error_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        plan_row_t                 plan [$];
        int unsigned               first_random;
        int unsigned               lap;
        logic [bd2_pkg::CFG_W-1:0] new_width;
        logic [bd2_pkg::CFG_W-1:0] new_height;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset geometry: part of the first row, then shrink to close the frame
        set_idle(IDLE_NONE);
        repeat (12) feed_pixel(any_pixel(), 1'b0, '0);
        write_reg(bd2_pkg::REG_FRAME_WIDTH, 12'd12);
        write_reg(bd2_pkg::REG_FRAME_HEIGHT, 12'd2);
        finish_frame();

        plan.push_back(reg_row(bd2_pkg::REG_FRAME_WIDTH, 12'd2));
        plan.push_back(reg_row(bd2_pkg::REG_FRAME_HEIGHT, 12'd2));
        plan.push_back(pixel_row(8'd255, 1'b0, 8'd0, 1'b0));
        plan.push_back(pixel_row(8'd255, 1'b0, 8'd0, 1'b0));
        plan.push_back(pixel_row(8'd255, 1'b0, 8'd0, 1'b0));
        plan.push_back(pixel_row(8'd255, 1'b1, 8'd255, 1'b1));
        plan.push_back(pixel_row(8'd0, 1'b0, 8'd0, 1'b0));
        plan.push_back(pixel_row(8'd0, 1'b0, 8'd0, 1'b0));
        plan.push_back(pixel_row(8'd0, 1'b0, 8'd0, 1'b0));
        plan.push_back(pixel_row(8'd0, 1'b1, 8'd0, 1'b1));
        // Truncation: a sum of 1019 floors to 254
        plan.push_back(pixel_row(8'd255, 1'b0, 8'd0, 1'b0));
        plan.push_back(pixel_row(8'd255, 1'b0, 8'd0, 1'b0));
        plan.push_back(pixel_row(8'd255, 1'b0, 8'd0, 1'b0));
        plan.push_back(pixel_row(8'd254, 1'b1, 8'd254, 1'b1));
        // Writes to unused indexes must leave the geometry alone
        plan.push_back(reg_row(REG_SPARE_A, 12'hFFF));
        plan.push_back(reg_row(REG_SPARE_B, 12'h000));
        plan.push_back(pixel_row(8'd200, 1'b0, 8'd0, 1'b0));
        plan.push_back(pixel_row(8'd100, 1'b0, 8'd0, 1'b0));
        plan.push_back(pixel_row(8'd50, 1'b0, 8'd0, 1'b0));
        plan.push_back(pixel_row(8'd25, 1'b1, 8'd93, 1'b1));
        // Odd width and height: trailing column and row give nothing
        plan.push_back(reg_row(bd2_pkg::REG_FRAME_WIDTH, 12'd3));
        plan.push_back(reg_row(bd2_pkg::REG_FRAME_HEIGHT, 12'd3));
        plan.push_back(pixel_row(8'd10, 1'b0, 8'd0, 1'b0));
        plan.push_back(pixel_row(8'd20, 1'b0, 8'd0, 1'b0));
        plan.push_back(pixel_row(8'd30, 1'b0, 8'd0, 1'b0));
        plan.push_back(pixel_row(8'd40, 1'b0, 8'd0, 1'b0));
        plan.push_back(pixel_row(8'd50, 1'b1, 8'd30, 1'b1));
        plan.push_back(pixel_row(8'd60, 1'b0, 8'd0, 1'b0));
        plan.push_back(pixel_row(8'd70, 1'b0, 8'd0, 1'b0));
        plan.push_back(pixel_row(8'd80, 1'b0, 8'd0, 1'b0));
        plan.push_back(pixel_row(8'd90, 1'b0, 8'd0, 1'b0));

        foreach (plan[i]) begin
            if (plan[i].is_reg_write)
                write_reg(plan[i].reg_index, plan[i].reg_value);
            else
                feed_pixel(plan[i].pixel, plan[i].has_result, plan[i].result);
        end

        first_random = pixels_sent;
        lap = 0;
        while (pixels_sent - first_random < RANDOM_PIXELS) begin
            set_idle(idle_mode_t'(lap % 4));
            lap++;
            new_width  = random_dim(12, 48);
            new_height = random_dim(6, 12);
            // Mid-frame, only shrink: the line buffer is then never read where unwritten
            if (col_pos != 0 || row_pos != 0) begin
                if (clamp_dim(new_width, bd2_pkg::MAX_WIDTH) >
                    clamp_dim(frame_width_reg, bd2_pkg::MAX_WIDTH))
                    new_width = frame_width_reg;
                if (clamp_dim(new_height, bd2_pkg::MAX_HEIGHT) >
                    clamp_dim(frame_height_reg, bd2_pkg::MAX_HEIGHT))
                    new_height = frame_height_reg;
            end
            write_reg(bd2_pkg::REG_FRAME_WIDTH, new_width);
            write_reg(bd2_pkg::REG_FRAME_HEIGHT, new_height);
            repeat ($urandom_range(3, 1)) send_frame();
            // Leave a part-frame behind for the next reconfiguration
            if ($urandom_range(1) == 1)
                repeat ($urandom_range(40, 1)) feed_pixel(any_pixel(), 1'b0, '0);
        end

        finish_frame();

        // Width above range clamps to the full line buffer; shrink after part of a row
        set_idle(IDLE_BOTH);
        write_reg(bd2_pkg::REG_FRAME_WIDTH, '1);
        write_reg(bd2_pkg::REG_FRAME_HEIGHT, 12'd2);
        repeat (40) feed_pixel(any_pixel(), 1'b0, '0);
        write_reg(bd2_pkg::REG_FRAME_WIDTH, 12'd8);
        finish_frame();

        // Height above range clamps as well; shrink after some rows
        set_idle(IDLE_SINK);
        write_reg(bd2_pkg::REG_FRAME_WIDTH, 12'd2);
        write_reg(bd2_pkg::REG_FRAME_HEIGHT, '1);
        repeat (40) feed_pixel(any_pixel(), 1'b0, '0);
        write_reg(bd2_pkg::REG_FRAME_HEIGHT, 12'd24);
        finish_frame();

        // Largest legal sizes, then shrink under a part-written row
        set_idle(IDLE_SOURCE);
        write_reg(bd2_pkg::REG_FRAME_WIDTH, bd2_pkg::CFG_W'(bd2_pkg::MAX_WIDTH));
        write_reg(bd2_pkg::REG_FRAME_HEIGHT, bd2_pkg::CFG_W'(bd2_pkg::MAX_HEIGHT));
        repeat (37) feed_pixel(any_pixel(), 1'b0, '0);
        write_reg(bd2_pkg::REG_FRAME_WIDTH, 12'd4);
        write_reg(bd2_pkg::REG_FRAME_HEIGHT, 12'd2);
        finish_frame();
        send_frame();

        wait_idle();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
